@@ design/bec_pkg.sv @@
`timescale 1ns / 1ps

package bec_pkg;

    // Field widths fixed by the interface.
    localparam int FIELD_W     = 11;
    localparam int DT_W        = 10;
    localparam int TIME_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_BUTTONS = 32;

    // Default number of buttons served by the lane.
    localparam int NUM_BUTTONS_DEF = 11;

    // Register reset values.
    localparam logic [FIELD_W-1:0] ENABLED_RST  = 11'd2047;
    localparam logic [FIELD_W-1:0] IDLE_RST     = 11'd1024;
    localparam logic [TIME_W-1:0]  PRESS_TH_RST = 16'd100;
    localparam logic [TIME_W-1:0]  LONG_TH_RST  = 16'd2000;

    // Saturation value of the held-time counter.
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED  = 2'd0,
        REG_IDLE     = 2'd1,
        REG_PRESS_TH = 2'd2,
        REG_LONG_TH  = 2'd3
    } t_cfg_idx;

    // One button's stored state: pressed flag above held time.
    typedef struct packed {
        logic              flag;
        logic [TIME_W-1:0] held;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Everything the lane needs to classify one button.
    typedef struct packed {
        logic              enabled;
        logic              pin;
        logic              idle;
        t_entry            old;
        logic [DT_W-1:0]   dt;
        logic [TIME_W-1:0] press_th;
        logic [TIME_W-1:0] long_th;
    } t_lane_in;

    // Lane verdict: write-back request, new state and event bits.
    typedef struct packed {
        logic   we;
        t_entry upd;
        logic   press;
        logic   hold;
        logic   rel;
        logic   lrel;
    } t_lane_out;

endpackage

@@ design/bec_ram.sv @@
`timescale 1ns / 1ps

module bec_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 11,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds without a read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bec_lane.sv @@
`timescale 1ns / 1ps

module bec_lane
    import bec_pkg::*;
(
    input  t_lane_in  i_in,
    output t_lane_out o_out
);

    logic              at_idle;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] sat;

    // Saturating add of the elapsed time.
    assign sum = {1'b0, i_in.old.held} + {{(TIME_W + 1 - DT_W){1'b0}}, i_in.dt};
    assign sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    assign at_idle = (i_in.pin == i_in.idle);

    // Classify one button and compute its new state.
    always_comb begin
        o_out = '0;
        if (i_in.enabled) begin
            o_out.we = 1'b1;
            if (at_idle) begin
                o_out.upd.flag = 1'b0;
                o_out.upd.held = '0;
                o_out.rel      = i_in.old.flag && (i_in.old.held > i_in.press_th);
                o_out.lrel     = i_in.old.flag && (i_in.old.held > i_in.long_th);
            end else begin
                o_out.upd.flag = 1'b1;
                o_out.upd.held = sat;
                o_out.press    = !i_in.old.flag;
                o_out.hold     = i_in.old.held > i_in.press_th;
            end
        end
    end

endmodule

@@ design/button_event_classifier.sv @@
`timescale 1ns / 1ps

// Button event classifier. Each input transfer (one tick: pin levels and the
// milliseconds since the previous tick) produces exactly one output transfer
// holding press, hold, release and long-release bit masks. The per-button
// pressed flag and 16-bit held time live in a small RAM with a registered read;
// a single lane walks the buttons, reading an entry through the RAM read register
// and writing it back from the classify stage. A tick therefore occupies the lane
// for one issue per button (11 buttons by default), and the next tick is accepted
// as the last button of the current one is read, before the current tick's
// result is out. The finished result passes the classify stage and waits in an output
// register; the lane stalls only if a finished result is still untaken.
// Configuration writes take effect at once and are meant for idle periods.

module button_event_classifier
    import bec_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Tick input channel.
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [FIELD_W-1:0]    i_pin_levels,
    input  logic [DT_W-1:0]       i_elapsed_ms,
    // Event output channel.
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FIELD_W-1:0]    o_press_events,
    output logic [FIELD_W-1:0]    o_hold_events,
    output logic [FIELD_W-1:0]    o_release_events,
    output logic [FIELD_W-1:0]    o_long_release_events
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);
    localparam int PAD_W = MAX_BUTTONS - FIELD_W;

    // Configuration registers.
    logic [FIELD_W-1:0] r_enabled;
    logic [FIELD_W-1:0] r_idle;
    logic [TIME_W-1:0]  r_press_th;
    logic [TIME_W-1:0]  r_long_th;

    // Issue stage: current tick and the button being read.
    logic               r_busy;
    logic [IDX_W-1:0]   r_idx;
    logic [FIELD_W-1:0] r_pins;
    logic [DT_W-1:0]    r_dt;

    // Classify stage: one button whose entry is on the RAM read port.
    logic               r_s2_valid;
    logic               r_s2_first;
    logic               r_s2_last;
    logic [IDX_W-1:0]   r_s2_idx;
    logic               r_s2_pin;
    logic [DT_W-1:0]    r_s2_dt;
    logic               r_s2_vld;
    logic               r_fwd_hit;
    t_entry             r_fwd_data;

    // Entry written-since-reset bits; an unwritten entry reads as cleared.
    logic [NUM_BUTTONS-1:0] r_valid;

    // Event accumulators and output register.
    logic [FIELD_W-1:0] r_acc_press, r_acc_hold, r_acc_rel, r_acc_lrel;
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_press, r_out_hold, r_out_rel, r_out_lrel;

    logic               stall;
    logic               issue;
    logic               issue_last;
    logic               in_xfer;
    logic               we;
    logic [ENTRY_W-1:0] rdata;
    t_entry             old_entry;
    t_lane_in           lane_in;
    t_lane_out          lane_out;
    logic [MAX_BUTTONS-1:0] pins_ext;
    logic [MAX_BUTTONS-1:0] en_ext;
    logic [MAX_BUTTONS-1:0] idle_ext;
    logic [MAX_BUTTONS-1:0] s2_onehot;
    logic [FIELD_W-1:0] bit_sel;
    logic [FIELD_W-1:0] n_press, n_hold, n_rel, n_lrel;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= ENABLED_RST;
            r_idle     <= IDLE_RST;
            r_press_th <= PRESS_TH_RST;
            r_long_th  <= LONG_TH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_ENABLED:  r_enabled  <= i_cfg_data[FIELD_W-1:0];
                REG_IDLE:     r_idle     <= i_cfg_data[FIELD_W-1:0];
                REG_PRESS_TH: r_press_th <= i_cfg_data[TIME_W-1:0];
                REG_LONG_TH:  r_long_th  <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Lane control: hold everything while a finished result cannot be handed over.
    assign stall      = r_s2_valid && r_s2_last && r_out_valid && !i_ready;
    assign issue      = r_busy && !stall;
    assign issue_last = issue && (r_idx == LAST_IDX);
    assign o_ready    = !r_busy || issue_last;
    assign in_xfer    = i_valid && o_ready;

    // Issue stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (in_xfer) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (issue_last) begin
            r_busy <= 1'b0;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pins <= i_pin_levels;
            r_dt   <= i_elapsed_ms;
        end
    end

    // Masks widened so that buttons past the field width read as disabled.
    assign pins_ext = {{PAD_W{1'b0}}, r_pins};
    assign en_ext   = {{PAD_W{1'b0}}, r_enabled};
    assign idle_ext = {{PAD_W{1'b0}}, r_idle};

    // Classify stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!stall) begin
            r_s2_valid <= issue;
        end
    end

    // Carry the tick fields along with the read, and catch a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2_first <= (r_idx == '0);
            r_s2_last  <= (r_idx == LAST_IDX);
            r_s2_idx   <= r_idx;
            r_s2_pin   <= pins_ext[r_idx];
            r_s2_dt    <= r_dt;
            r_s2_vld   <= r_valid[r_idx];
            r_fwd_hit  <= we && (r_s2_idx == r_idx);
            r_fwd_data <= lane_out.upd;
        end
    end

    // State memory.
    bec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUTTONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s2_idx),
        .i_wdata (lane_out.upd),
        .i_re    (issue),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    // Pick the freshest copy of the entry.
    always_comb begin
        if (r_fwd_hit) begin
            old_entry = r_fwd_data;
        end else if (r_s2_vld) begin
            old_entry = t_entry'(rdata);
        end else begin
            old_entry = '0;
        end
    end

    assign s2_onehot = MAX_BUTTONS'(1) << r_s2_idx;

    always_comb begin
        lane_in.enabled  = |(en_ext & s2_onehot);
        lane_in.pin      = r_s2_pin;
        lane_in.idle     = |(idle_ext & s2_onehot);
        lane_in.old      = old_entry;
        lane_in.dt       = r_s2_dt;
        lane_in.press_th = r_press_th;
        lane_in.long_th  = r_long_th;
    end

    bec_lane u_lane (
        .i_in  (lane_in),
        .o_out (lane_out)
    );

    assign we = r_s2_valid && !stall && lane_out.we;

    // Entry valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[r_s2_idx] <= 1'b1;
        end
    end

    // Merge this button's events into the tick's masks.
    assign bit_sel = s2_onehot[FIELD_W-1:0];

    always_comb begin
        if (r_s2_first) begin
            n_press = '0;
            n_hold  = '0;
            n_rel   = '0;
            n_lrel  = '0;
        end else begin
            n_press = r_acc_press;
            n_hold  = r_acc_hold;
            n_rel   = r_acc_rel;
            n_lrel  = r_acc_lrel;
        end
        n_press = n_press | (bit_sel & {FIELD_W{lane_out.press}});
        n_hold  = n_hold  | (bit_sel & {FIELD_W{lane_out.hold}});
        n_rel   = n_rel   | (bit_sel & {FIELD_W{lane_out.rel}});
        n_lrel  = n_lrel  | (bit_sel & {FIELD_W{lane_out.lrel}});
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && !stall) begin
            r_acc_press <= n_press;
            r_acc_hold  <= n_hold;
            r_acc_rel   <= n_rel;
            r_acc_lrel  <= n_lrel;
        end
    end

    // Output register: loaded at the last button, cleared on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s2_valid && r_s2_last && !stall) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_s2_last && !stall) begin
            r_out_press <= n_press;
            r_out_hold  <= n_hold;
            r_out_rel   <= n_rel;
            r_out_lrel  <= n_lrel;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_press_events        = r_out_press;
    assign o_hold_events         = r_out_hold;
    assign o_release_events      = r_out_rel;
    assign o_long_release_events = r_out_lrel;

endmodule

@@ tb/sv/button_event_classifier_test.sv @@
`timescale 1ns / 1ps

module button_event_classifier_test
    import bec_pkg::*;
;

    localparam int CLK_HALF        = 6;
    localparam int RST_CYCLES      = 11;
    localparam int RANDOM_TICKS    = 1500;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 40;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int MAX_REPORTS     = 10;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef enum {OP_TICK, OP_WRITE, OP_DRAIN} t_op_kind;

    // One planned action for the sender: a tick, a register write, or a pause.
    typedef struct {
        t_op_kind              kind;
        logic [FIELD_W-1:0]    pins;
        logic [DT_W-1:0]       dt;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_stim_op;

    // Event masks of one tick, in output port order.
    typedef struct packed {
        logic [FIELD_W-1:0] press;
        logic [FIELD_W-1:0] hold;
        logic [FIELD_W-1:0] rel;
        logic [FIELD_W-1:0] lrel;
    } t_events;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = REG_ENABLED;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic                  o_ready;
    logic [FIELD_W-1:0]    i_pin_levels = '0;
    logic [DT_W-1:0]       i_elapsed_ms = '0;
    logic                  o_valid;
    logic                  i_ready      = 1'b0;
    logic [FIELD_W-1:0]    o_press_events;
    logic [FIELD_W-1:0]    o_hold_events;
    logic [FIELD_W-1:0]    o_release_events;
    logic [FIELD_W-1:0]    o_long_release_events;

    // Predicted register file and per-button state.
    logic [FIELD_W-1:0] cfg_enabled;
    logic [FIELD_W-1:0] cfg_idle;
    logic [TIME_W-1:0]  cfg_press_th;
    logic [TIME_W-1:0]  cfg_long_th;
    logic               btn_pressed [NUM_BUTTONS_DEF];
    logic [TIME_W-1:0]  btn_held    [NUM_BUTTONS_DEF];

    t_stim_op tick_plan[$];
    t_events  expected_events[$];

    int cycle_cnt      = 0;
    int outstanding    = 0;
    int ticks_in       = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int tx_gap         = 0;
    int rx_gap         = 0;
    int settle         = 0;
    int hold_off       = 0;
    int last_hold_tick = -1;

    // Windows of the run in which one side never idles.
    wire sender_calm   = ((cycle_cnt / 400) % 5) == 2;
    wire receiver_calm = ((cycle_cnt / 300) % 4) == 1;

    button_event_classifier u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_pin_levels          (i_pin_levels),
        .i_elapsed_ms          (i_elapsed_ms),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_press_events        (o_press_events),
        .o_hold_events         (o_hold_events),
        .o_release_events      (o_release_events),
        .o_long_release_events (o_long_release_events)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_mask();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return FIELD_W'($urandom);
    endfunction

    function automatic logic [TIME_W-1:0] rand_threshold();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return TIME_MAX;
        if (r == 2) return TIME_MAX - 1'b1;
        return TIME_W'($urandom_range(0, 3000));
    endfunction

    function automatic logic [DT_W-1:0] pick_dt(input bit big);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (big) return DT_W'($urandom_range(500, 1023));
        return DT_W'($urandom_range(0, 200));
    endfunction

    function automatic void add_tick(input logic [FIELD_W-1:0] pins,
                                     input logic [DT_W-1:0] dt);
        tick_plan.push_back('{OP_TICK, pins, dt, REG_ENABLED, '0});
    endfunction

    function automatic void add_write(input t_cfg_idx idx,
                                      input logic [CFG_DATA_W-1:0] data);
        tick_plan.push_back('{OP_WRITE, '0, '0, idx, data});
    endfunction

    function automatic void add_drain();
        tick_plan.push_back('{OP_DRAIN, '0, '0, REG_ENABLED, '0});
    endfunction

    function automatic void write_reg(input t_cfg_idx idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENABLED:  cfg_enabled  = data[FIELD_W-1:0];
            REG_IDLE:     cfg_idle     = data[FIELD_W-1:0];
            REG_PRESS_TH: cfg_press_th = data[TIME_W-1:0];
            REG_LONG_TH:  cfg_long_th  = data[TIME_W-1:0];
            default: ;
        endcase
    endfunction

    // Classify one tick against the predicted state and advance that state.
    function automatic t_events classify_tick(input logic [FIELD_W-1:0] pins,
                                              input logic [DT_W-1:0] dt);
        t_events         ev;
        logic [TIME_W:0] sum;
        ev = '0;
        for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
            if (cfg_enabled[b]) begin
                if (pins[b] == cfg_idle[b]) begin
                    if (btn_pressed[b]) begin
                        ev.lrel[b] = btn_held[b] > cfg_long_th;
                        ev.rel[b]  = btn_held[b] > cfg_press_th;
                    end
                    btn_pressed[b] = 1'b0;
                    btn_held[b]    = '0;
                end else begin
                    ev.press[b]    = !btn_pressed[b];
                    ev.hold[b]     = btn_held[b] > cfg_press_th;
                    btn_pressed[b] = 1'b1;
                    sum            = btn_held[b] + dt;
                    btn_held[b]    = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
                end
            end
        end
        return ev;
    endfunction

    // Sender: ticks go out with random gaps; writes and pauses wait for a drained block.
    always @(posedge i_clk) begin
        t_stim_op op;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_cfg_we <= 1'b0;
            tx_gap   <= 0;
            settle   <= 0;
        end else if (i_valid && !o_ready) begin
            i_valid <= 1'b1;
        end else if (tx_gap != 0) begin
            i_valid  <= 1'b0;
            i_cfg_we <= 1'b0;
            tx_gap   <= tx_gap - 1;
        end else if (tick_plan.size() == 0) begin
            i_valid  <= 1'b0;
            i_cfg_we <= 1'b0;
        end else if (tick_plan[0].kind == OP_TICK) begin
            op = tick_plan.pop_front();
            i_valid      <= 1'b1;
            i_pin_levels <= op.pins;
            i_elapsed_ms <= op.dt;
            i_cfg_we     <= 1'b0;
            settle       <= 0;
            tx_gap       <= (sender_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        end else if (outstanding != 0 || i_valid) begin
            i_valid  <= 1'b0;
            i_cfg_we <= 1'b0;
            settle   <= 0;
        end else if (settle < SETTLE_CYCLES) begin
            i_cfg_we <= 1'b0;
            settle   <= settle + 1;
        end else begin
            op = tick_plan.pop_front();
            i_cfg_we   <= (op.kind == OP_WRITE);
            i_cfg_idx  <= op.idx;
            i_cfg_data <= op.data;
        end
    end

    // Predictor and checker; also paces the receiver side.
    always @(posedge i_clk) begin
        t_events want;
        t_events got;
        if (!i_rst_n) begin
            cfg_enabled  = ENABLED_RST;
            cfg_idle     = IDLE_RST;
            cfg_press_th = PRESS_TH_RST;
            cfg_long_th  = LONG_TH_RST;
            for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
                btn_pressed[b] = 1'b0;
                btn_held[b]    = '0;
            end
            expected_events.delete();
            outstanding <= 0;
            ticks_in    <= 0;
            i_ready     <= 1'b0;
            rx_gap = 0;
        end else begin
            if (i_cfg_we) write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            if (i_valid && o_ready) begin
                expected_events.push_back(classify_tick(i_pin_levels, i_elapsed_ms));
                ticks_in <= ticks_in + 1;
            end
            if (o_valid && i_ready) begin
                got = {o_press_events, o_hold_events, o_release_events,
                       o_long_release_events};
                results_seen++;
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d arrived with no tick pending: ",
                                 "press=%h hold=%h rel=%h lrel=%h",
                                 results_seen, got.press, got.hold, got.rel, got.lrel);
                end else begin
                    want = expected_events.pop_front();
                    if (got.press !== want.press || got.hold !== want.hold ||
                        got.rel !== want.rel || got.lrel !== want.lrel) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result %0d: expected press=%h hold=%h rel=%h lrel=%h, ",
                                     "got press=%h hold=%h rel=%h lrel=%h",
                                     results_seen, want.press, want.hold, want.rel,
                                     want.lrel, got.press, got.hold, got.rel, got.lrel);
                    end
                end
            end
            outstanding <= expected_events.size();

            if (hold_off != 0) begin
                i_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                i_ready <= 1'b0;
                rx_gap--;
            end else begin
                i_ready <= 1'b1;
                if (!receiver_calm && $urandom_range(0, 5) == 0) rx_gap = pick_gap();
            end
        end
    end

    // Long receiver hold-offs at a few points so the block backs up into the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off       <= 0;
            last_hold_tick <= -1;
        end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
        end else if ((ticks_in == 400 || ticks_in == 800 || ticks_in == 1200) &&
                     ticks_in != last_hold_tick) begin
            hold_off       <= HOLD_OFF_CYCLES;
            last_hold_tick <= ticks_in;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [FIELD_W-1:0]    level;
        logic [FIELD_W-1:0]    plan_idle;
        logic [TIME_W-1:0]     pth;
        logic [CFG_DATA_W-1:0] wd;
        int                    made;
        int                    seg_len;
        int                    flip_div;
        bit                    big_dt;

        // Default settings: press, hold and release around both thresholds.
        add_tick(11'h400, 0);
        add_tick(11'h000, 0);
        add_tick(11'h7FF, 1023);
        add_tick(11'h3FF, 1023);
        add_tick(11'h400, 7);
        add_tick(11'h001, 100);
        add_tick(11'h001, 1);
        add_tick(11'h001, 0);
        add_tick(11'h400, 0);
        add_tick(11'h002, 1023);
        add_tick(11'h002, 977);
        add_tick(11'h400, 0);

        // Disabled buttons keep their flag and time while their pins move.
        add_tick(11'h3FF, 500);
        add_write(REG_ENABLED, 16'h02AA);
        add_tick(11'h400, 0);
        add_tick(11'h000, 9);
        add_write(REG_ENABLED, 16'hFFFF);
        add_tick(11'h3FF, 0);
        add_tick(11'h400, 0);

        // Zero thresholds: a zero held time still never counts.
        add_write(REG_PRESS_TH, 16'h0000);
        add_write(REG_LONG_TH, 16'h0000);
        add_tick(11'h010, 0);
        add_tick(11'h010, 0);
        add_tick(11'h400, 0);
        add_tick(11'h010, 1);
        add_tick(11'h010, 0);
        add_tick(11'h400, 0);

        // Counter saturation: one below the top fires, the top itself never does.
        add_write(REG_IDLE, 16'h0000);
        add_write(REG_PRESS_TH, TIME_MAX - 1'b1);
        add_write(REG_LONG_TH, TIME_MAX - 1'b1);
        repeat (66) add_tick(11'h7FF, 1023);
        add_tick(11'h000, 0);
        add_write(REG_PRESS_TH, TIME_MAX);
        add_write(REG_LONG_TH, TIME_MAX);
        repeat (66) add_tick(11'h0F0, 1023);
        add_tick(11'h000, 0);
        add_drain();

        // Random segments: buttons flip now and then from their idle levels,
        // with some ticks of fully random pins mixed in.
        level = '0;
        made  = 0;
        while (made < RANDOM_TICKS) begin
            if ($urandom_range(0, 4) == 0) begin
                add_drain();
            end else begin
                plan_idle = rand_mask();
                wd = CFG_DATA_W'($urandom);
                wd[FIELD_W-1:0] = rand_mask();
                add_write(REG_ENABLED, wd);
                wd = CFG_DATA_W'($urandom);
                wd[FIELD_W-1:0] = plan_idle;
                add_write(REG_IDLE, wd);
                pth = rand_threshold();
                add_write(REG_PRESS_TH, pth);
                case ($urandom_range(0, 3))
                    0: add_write(REG_LONG_TH, rand_threshold());
                    1: add_write(REG_LONG_TH, pth);
                    default: add_write(REG_LONG_TH, (pth > TIME_MAX - 8000) ? TIME_MAX :
                                       CFG_DATA_W'(pth + $urandom_range(0, 8000)));
                endcase
                level = plan_idle;
            end
            seg_len  = $urandom_range(30, 150);
            flip_div = $urandom_range(2, 24);
            big_dt   = ($urandom_range(0, 7) == 0);
            for (int n = 0; n < seg_len; n++) begin
                if ($urandom_range(0, 11) == 0) begin
                    add_tick(FIELD_W'($urandom), pick_dt(big_dt));
                end else begin
                    for (int b = 0; b < FIELD_W; b++)
                        if ($urandom_range(1, flip_div) == 1) level[b] = ~level[b];
                    add_tick(level, pick_dt(big_dt));
                end
            end
            made += seg_len;
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the plan to run out and every tick to come back.
        while (tick_plan.size() != 0 || i_valid || i_cfg_we || outstanding != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/bec_pkg.sv
design/bec_ram.sv
design/bec_lane.sv
design/button_event_classifier.sv
tb/sv/button_event_classifier_test.sv
